/* rtl/etc_pkg.sv */
// Shared types and constants of the edge-triggered multichannel capture block.
package etc_pkg;

  // Fixed field widths of the channels and the configuration port
  localparam int SAMPLE_BITS   = 16;
  localparam int CHANNELS      = 4;
  localparam int CHAN_BITS     = 2;
  localparam int CHAN_CNT_BITS = 3;
  localparam int INDEX_BITS    = 10;
  localparam int COUNT_BITS    = 11;
  localparam int REQ_BITS      = 2;
  localparam int CFG_ADDR_BITS = 2;
  localparam int CFG_DATA_BITS = 16;

  // Default capture depth in frames (range 2 to 1024)
  localparam int CAPTURE_DEPTH = 1024;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // Request codes
  typedef enum logic [REQ_BITS-1:0] {
    REQ_FRAME = 2'd0,
    REQ_ARM   = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  // Trigger phases as reported on the result channel
  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_OPPOSITE = 2'd1,
    PH_CROSSING = 2'd2,
    PH_CAPTURE  = 2'd3
  } phase_t;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_BITS-1:0] {
    CFG_TRIGGER_CHANNEL = 2'd0,
    CFG_TRIGGER_LEVEL   = 2'd1,
    CFG_RISING_EDGE     = 2'd2,
    CFG_CHANNELS_USED   = 2'd3
  } cfg_index_t;

endpackage

/* rtl/etc_if.sv */
// Valid/ready channel interfaces for sample frames and capture results.
interface etc_frame_if;
  import etc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [REQ_BITS-1:0]   req_type;
  sample_t               sample_ch0;
  sample_t               sample_ch1;
  sample_t               sample_ch2;
  sample_t               sample_ch3;
  logic [INDEX_BITS-1:0] read_index;
  logic [CHAN_BITS-1:0]  read_channel;

  modport source (
    output valid, req_type, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
           read_index, read_channel,
    input  ready
  );
  modport sink (
    input  valid, req_type, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
           read_index, read_channel,
    output ready
  );
endinterface

interface etc_result_if;
  import etc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [1:0]            phase;
  logic                  frame_stored;
  logic [COUNT_BITS-1:0] fill_count;
  logic                  memory_full;
  sample_t               read_data;

  modport source (
    output valid, phase, frame_stored, fill_count, memory_full, read_data,
    input  ready
  );
  modport sink (
    input  valid, phase, frame_stored, fill_count, memory_full, read_data,
    output ready
  );
endinterface

/* rtl/edge_triggered_multichannel_capture_top.sv */
// Top level of the edge-triggered multichannel capture block.
//
// One request is taken per clock cycle; its result is loaded into the result
// register at the transfer edge and a new request is taken in the same
// cycle as long as the result register is empty or is being drained. The
// trigger compare, the phase update and the capture write all happen at the
// transfer edge; a read request reads each channel memory at that edge and the
// registered read data of the synchronous memory read port feeds the result.
// The capture memory is one single-port write / single-port read array per
// channel, CAPTURE_DEPTH (2 to 1024) frames deep, with no reset and no
// clearing pass: entries are only read below the fill count. Configuration
// writes are taken on any cycle and must only be issued while no request is
// in flight.
module edge_triggered_multichannel_capture_top #(
  parameter int CAPTURE_DEPTH = etc_pkg::CAPTURE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [etc_pkg::CFG_ADDR_BITS-1:0] cfg_index,
  input  logic [etc_pkg::CFG_DATA_BITS-1:0] cfg_data,
  etc_frame_if.sink                        frame,
  etc_result_if.source                     result
);
  import etc_pkg::*;

  localparam int AW = (CAPTURE_DEPTH > 1) ? $clog2(CAPTURE_DEPTH) : 1;
  localparam int CW = $clog2(CAPTURE_DEPTH + 1);

  // Configuration registers
  logic [CHAN_BITS-1:0]     trig_chan;
  sample_t                  trig_level;
  logic                     rising;
  logic [CHAN_CNT_BITS-1:0] chan_used;

  // Capture state
  phase_t        phase;
  phase_t        phase_next;
  logic [AW-1:0] wr_pos;
  logic [CW-1:0] held;
  logic [CW-1:0] held_next;

  // Result register
  logic                  out_valid;
  phase_t                out_phase;
  logic                  out_stored;
  logic [CW-1:0]         out_held;
  logic                  out_rd_ok;
  logic [CHAN_BITS-1:0]  out_rd_chan;
  sample_t               rd_q [CHANNELS];

  logic                     accept;
  req_t                     req;
  logic [CHAN_CNT_BITS-1:0] nch;
  logic                     trig_ok;
  sample_t                  trig_sample;
  logic                     lt_level;
  logic                     gt_level;
  logic                     below;
  logic                     beyond;
  logic                     full;
  logic                     store_now;
  logic                     rd_ok;
  logic [AW-1:0]            rd_addr;
  sample_t                  frame_samples [CHANNELS];

  assign frame.ready = !out_valid || result.ready;
  assign accept      = frame.valid && frame.ready;
  assign req         = req_t'(frame.req_type);

  assign frame_samples[0] = frame.sample_ch0;
  assign frame_samples[1] = frame.sample_ch1;
  assign frame_samples[2] = frame.sample_ch2;
  assign frame_samples[3] = frame.sample_ch3;

  // Clamp the active channel count
  assign nch = (chan_used > CHAN_CNT_BITS'(CHANNELS)) ? CHAN_CNT_BITS'(CHANNELS) : chan_used;
  assign trig_ok = {1'b0, trig_chan} < nch;
  assign full    = held == CW'(CAPTURE_DEPTH);

  // Compare the trigger channel with the level
  assign trig_sample = frame_samples[trig_chan];
  assign lt_level    = trig_sample < trig_level;
  assign gt_level    = trig_sample > trig_level;
  assign below       = rising ? lt_level : gt_level;
  assign beyond      = rising ? gt_level : lt_level;

  // Advance the trigger phase and the fill count
  always_comb begin
    phase_next = phase;
    held_next  = held;
    store_now  = 1'b0;
    unique case (req)
      REQ_ARM: begin
        phase_next = PH_OPPOSITE;
        held_next  = '0;
      end
      REQ_FRAME: begin
        if (!full) begin
          if (trig_ok && phase == PH_OPPOSITE && below) begin
            phase_next = PH_CROSSING;
          end else if (trig_ok && phase == PH_CROSSING && beyond) begin
            phase_next = PH_CAPTURE;
          end
          if (phase_next == PH_CAPTURE) begin
            store_now = 1'b1;
            held_next = held + CW'(1);
          end
        end
      end
      REQ_READ: begin
      end
      default: begin
      end
    endcase
  end

  // Qualify a read against the fill count and the active channels
  assign rd_ok = (req == REQ_READ)
              && ({1'b0, frame.read_index} < COUNT_BITS'(held))
              && ({1'b0, frame.read_channel} < nch);
  assign rd_addr = AW'(frame.read_index);

  // Hold configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      trig_chan  <= '0;
      trig_level <= '0;
      rising     <= 1'b1;
      chan_used  <= CHAN_CNT_BITS'(CHANNELS);
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_TRIGGER_CHANNEL: trig_chan  <= cfg_data[CHAN_BITS-1:0];
        CFG_TRIGGER_LEVEL:   trig_level <= sample_t'(cfg_data);
        CFG_RISING_EDGE:     rising     <= cfg_data[0];
        CFG_CHANNELS_USED:   chan_used  <= cfg_data[CHAN_CNT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Update capture state on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_IDLE;
      held   <= '0;
      wr_pos <= '0;
    end else if (accept) begin
      phase <= phase_next;
      held  <= held_next;
      if (req == REQ_ARM) begin
        wr_pos <= '0;
      end else if (store_now) begin
        wr_pos <= (wr_pos == AW'(CAPTURE_DEPTH - 1)) ? '0 : wr_pos + AW'(1);
      end
    end
  end

  // Per-channel capture memories
  for (genvar j = 0; j < CHANNELS; j++) begin : g_mem
    sample_t mem [CAPTURE_DEPTH];

    always_ff @(posedge clk) begin
      if (accept && store_now && (CHAN_CNT_BITS'(j) < nch)) begin
        mem[wr_pos] <= frame_samples[j];
      end
    end

    always_ff @(posedge clk) begin
      if (accept) begin
        rd_q[j] <= mem[rd_addr];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_phase   <= phase_next;
      out_stored  <= store_now;
      out_held    <= held_next;
      out_rd_ok   <= rd_ok;
      out_rd_chan <= frame.read_channel;
    end
  end

  assign result.valid        = out_valid;
  assign result.phase        = out_phase;
  assign result.frame_stored = out_stored;
  assign result.fill_count   = COUNT_BITS'(out_held);
  assign result.memory_full  = out_held == CW'(CAPTURE_DEPTH);
  assign result.read_data    = out_rd_ok ? rd_q[out_rd_chan] : '0;

  // A stored frame is only reported while capturing
  assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.frame_stored) |-> (result.phase == PH_CAPTURE))
    else $error("stored frame reported outside capture phase");

  // A stored frame grows the fill count by exactly one
  assert property (@(posedge clk) disable iff (rst)
    (accept && store_now) |=> (held == $past(held) + CW'(1)))
    else $error("fill count did not advance on a stored frame");

  // Arm clears the fill count and write position and waits for the opposite side
  assert property (@(posedge clk) disable iff (rst)
    (accept && req == REQ_ARM) |=> (held == '0 && wr_pos == '0 && phase == PH_OPPOSITE))
    else $error("arm did not restart the capture");

endmodule

/* dv/testbench.sv */
// Self-checking bench for the edge-triggered multichannel capture block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import etc_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 7;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_OFF_CYCLES = 80;

  // Stimulus shaping for the trigger channel sample
  localparam int SIDE_ANY = 0;
  localparam int SIDE_START = 1;
  localparam int SIDE_CROSS = 2;
  localparam int SIDE_EQUAL = 3;

  // Idle patterns of the two channels
  localparam int IDLE_RX_HEAVY = 0;
  localparam int IDLE_TX_HEAVY = 1;
  localparam int IDLE_NONE = 2;

  typedef struct packed {
    req_t                  req;
    sample_t               s0;
    sample_t               s1;
    sample_t               s2;
    sample_t               s3;
    logic [INDEX_BITS-1:0] read_index;
    logic [CHAN_BITS-1:0]  read_channel;
  } capture_req_t;

  typedef struct packed {
    phase_t                phase;
    logic                  stored;
    logic [COUNT_BITS-1:0] fill;
    logic                  full;
    sample_t               rdata;
  } capture_reply_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_ADDR_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  etc_frame_if  frame_bus ();
  etc_result_if result_bus ();

  edge_triggered_multichannel_capture_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .frame     (frame_bus),
    .result    (result_bus)
  );

  always #HALF_PERIOD clk = ~clk;

  capture_req_t   frame_requests [$];
  capture_reply_t capture_replies [$];
  int mismatches = 0;
  int planned = 0;
  int cycle_count = 0;

  int idle_mode = IDLE_RX_HEAVY;
  int send_idle_pct = 12;
  int recv_idle_pct = 86;
  int hold_left = 0;
  bit hold_done = 1'b0;

  // Stimulus view of the configuration
  int gen_trig_ch = 0;
  int gen_level = 0;
  bit gen_rising = 1'b1;
  int gen_nch = CHANNELS;

  // Predicted block state and register copies
  logic [CHAN_BITS-1:0]     trig_ch = '0;
  sample_t                  trig_level = '0;
  logic                     rising = 1'b1;
  logic [CHAN_CNT_BITS-1:0] chans_used = 3'd4;
  phase_t                   cap_phase = PH_IDLE;
  logic [INDEX_BITS-1:0]    wr_pos = '0;
  logic [COUNT_BITS-1:0]    held = '0;
  sample_t                  capture_mem [0:CHANNELS-1][0:CAPTURE_DEPTH-1];

  function automatic sample_t sample_of(capture_req_t it, int ch);
    case (ch)
      0: return it.s0;
      1: return it.s1;
      2: return it.s2;
      default: return it.s3;
    endcase
  endfunction

  function automatic capture_req_t put_sample(capture_req_t it, int ch, sample_t v);
    case (ch)
      0: it.s0 = v;
      1: it.s1 = v;
      2: it.s2 = v;
      default: it.s3 = v;
    endcase
    return it;
  endfunction

  // Advance the capture state by one accepted request and form its reply
  function automatic capture_reply_t advance_capture(capture_req_t it);
    capture_reply_t r;
    int nch;
    int c;
    sample_t trig;
    logic start_side;
    logic far_side;
    r = '0;
    nch = (chans_used > CHANNELS) ? CHANNELS : int'(chans_used);
    case (it.req)
      REQ_ARM: begin
        cap_phase = PH_OPPOSITE;
        held = '0;
        wr_pos = '0;
      end
      REQ_FRAME: begin
        // A full memory drops the frame before any trigger check
        if (held < CAPTURE_DEPTH) begin
          if (int'(trig_ch) < nch) begin
            trig = sample_of(it, int'(trig_ch));
            start_side = rising ? (trig < trig_level) : (trig > trig_level);
            far_side = rising ? (trig > trig_level) : (trig < trig_level);
            if (cap_phase == PH_OPPOSITE && start_side) cap_phase = PH_CROSSING;
            if (cap_phase == PH_CROSSING && far_side) cap_phase = PH_CAPTURE;
          end
          if (cap_phase == PH_CAPTURE) begin
            for (c = 0; c < nch; c++) capture_mem[c][wr_pos] = sample_of(it, c);
            wr_pos = wr_pos + 1'b1;
            held = held + 1'b1;
            r.stored = 1'b1;
          end
        end
      end
      REQ_READ: begin
        if (it.read_index < held && int'(it.read_channel) < nch)
          r.rdata = capture_mem[it.read_channel][it.read_index];
      end
      default: ;
    endcase
    r.phase = cap_phase;
    r.fill = held;
    r.full = (held >= CAPTURE_DEPTH);
    return r;
  endfunction

  task automatic check_field(string field, int want, int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // Sender: hold the item until its transfer, then offer the next one
  always @(posedge clk) begin
    capture_req_t it;
    if (rst) begin
      frame_bus.valid <= 1'b0;
    end else if (!frame_bus.valid || frame_bus.ready) begin
      if (frame_requests.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        it = frame_requests.pop_front();
        frame_bus.req_type <= it.req;
        frame_bus.sample_ch0 <= it.s0;
        frame_bus.sample_ch1 <= it.s1;
        frame_bus.sample_ch2 <= it.s2;
        frame_bus.sample_ch3 <= it.s3;
        frame_bus.read_index <= it.read_index;
        frame_bus.read_channel <= it.read_channel;
        frame_bus.valid <= 1'b1;
      end else begin
        frame_bus.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off with no idle pattern
  always @(posedge clk) begin
    if (rst) begin
      result_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_bus.ready <= 1'b0;
    end else if (idle_mode == IDLE_NONE && !hold_done && frame_bus.valid) begin
      hold_left <= HOLD_OFF_CYCLES;
      hold_done <= 1'b1;
      result_bus.ready <= 1'b0;
    end else begin
      result_bus.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // Monitor: track register writes, check replies, predict on each request transfer
  always @(posedge clk) begin
    capture_req_t it;
    capture_reply_t want;
    if (!rst) begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TRIGGER_CHANNEL: trig_ch = cfg_data[CHAN_BITS-1:0];
          CFG_TRIGGER_LEVEL:   trig_level = cfg_data;
          CFG_RISING_EDGE:     rising = cfg_data[0];
          CFG_CHANNELS_USED:   chans_used = cfg_data[CHAN_CNT_BITS-1:0];
          default: ;
        endcase
      end
      if (result_bus.valid && result_bus.ready) begin
        if (capture_replies.size() == 0) begin
          mismatches++;
          $display("%0t: reply with no request pending, expected none, actual phase %0d",
                   $time, result_bus.phase);
        end else begin
          want = capture_replies.pop_front();
          check_field("phase", int'(want.phase), int'(result_bus.phase));
          check_field("frame_stored", int'(want.stored), int'(result_bus.frame_stored));
          check_field("fill_count", int'(want.fill), int'(result_bus.fill_count));
          check_field("memory_full", int'(want.full), int'(result_bus.memory_full));
          check_field("read_data", int'(want.rdata), int'(result_bus.read_data));
        end
      end
      if (frame_bus.valid && frame_bus.ready) begin
        it.req = req_t'(frame_bus.req_type);
        it.s0 = frame_bus.sample_ch0;
        it.s1 = frame_bus.sample_ch1;
        it.s2 = frame_bus.sample_ch2;
        it.s3 = frame_bus.sample_ch3;
        it.read_index = frame_bus.read_index;
        it.read_channel = frame_bus.read_channel;
        capture_replies.push_back(advance_capture(it));
      end
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL edge_triggered_multichannel_capture_top");
      $finish;
    end
  end

  function automatic capture_req_t random_req(req_t kind);
    capture_req_t it;
    it.req = kind;
    it.s0 = sample_t'($urandom());
    it.s1 = sample_t'($urandom());
    it.s2 = sample_t'($urandom());
    it.s3 = sample_t'($urandom());
    it.read_index = INDEX_BITS'($urandom_range(CAPTURE_DEPTH - 1, 0));
    it.read_channel = CHAN_BITS'($urandom_range(CHANNELS - 1, 0));
    return it;
  endfunction

  // Pick a trigger sample on the wanted side of the level for the current edge
  function automatic sample_t side_value(int side);
    int lo;
    int hi;
    bit low_half;
    sample_t v;
    v = sample_t'(gen_level);
    if (side != SIDE_EQUAL) begin
      low_half = (side == SIDE_START) ? gen_rising : !gen_rising;
      lo = low_half ? -32768 : gen_level + 1;
      hi = low_half ? gen_level - 1 : 32767;
      if (hi >= lo) begin
        case ($urandom_range(7, 0))
          0: v = sample_t'(lo);
          1: v = sample_t'(hi);
          default: v = sample_t'(lo + int'($urandom_range(hi - lo, 0)));
        endcase
      end
    end
    return v;
  endfunction

  task automatic push_req(capture_req_t it);
    frame_requests.push_back(it);
    planned++;
  endtask

  task automatic push_plain(req_t kind);
    push_req(random_req(kind));
  endtask

  task automatic push_frame(int side);
    capture_req_t it;
    it = random_req(REQ_FRAME);
    if (side != SIDE_ANY)
      it = put_sample(it, gen_trig_ch, side_value(side));
    else if ($urandom_range(7, 0) == 0)
      it = put_sample(it, gen_trig_ch, side_value(SIDE_EQUAL));
    push_req(it);
  endtask

  task automatic push_samples(int v0, int v1, int v2, int v3);
    capture_req_t it;
    it = random_req(REQ_FRAME);
    it.s0 = sample_t'(v0);
    it.s1 = sample_t'(v1);
    it.s2 = sample_t'(v2);
    it.s3 = sample_t'(v3);
    push_req(it);
  endtask

  task automatic push_read(int idx, int ch);
    capture_req_t it;
    it = random_req(REQ_READ);
    it.read_index = INDEX_BITS'(idx);
    it.read_channel = CHAN_BITS'(ch);
    push_req(it);
  endtask

  // Arm, approach from the start side, cross, capture a few frames, read back
  task automatic gen_sequence();
    int n_cap;
    n_cap = $urandom_range(20, 0);
    push_plain(REQ_ARM);
    repeat ($urandom_range(2, 0)) push_frame(SIDE_ANY);
    repeat ($urandom_range(2, 1)) push_frame(SIDE_START);
    repeat ($urandom_range(1, 0)) push_frame(SIDE_EQUAL);
    push_frame(SIDE_CROSS);
    repeat (n_cap) push_frame(SIDE_ANY);
    repeat ($urandom_range(6, 1))
      push_read($urandom_range(n_cap + 2, 0), $urandom_range(CHANNELS - 1, 0));
    if ($urandom_range(3, 0) == 0) push_plain(REQ_NONE);
  endtask

  task automatic gen_noise();
    case ($urandom_range(3, 0))
      0: push_frame(SIDE_ANY);
      1: push_plain(REQ_ARM);
      2: push_plain(REQ_READ);
      default: push_plain(REQ_NONE);
    endcase
  endtask

  // Fill the whole memory, drop the frames beyond it, then read the far end
  task automatic fill_memory();
    int c;
    push_plain(REQ_ARM);
    push_frame(SIDE_START);
    push_frame(SIDE_CROSS);
    repeat (CAPTURE_DEPTH + 6) push_frame(SIDE_ANY);
    for (c = 0; c < CHANNELS; c++) push_read(CAPTURE_DEPTH - 1, c);
    repeat (8) push_plain(REQ_READ);
    push_plain(REQ_NONE);
    push_plain(REQ_ARM);
  endtask

  // Block until every request is sent and every reply has come back
  task automatic wait_idle();
    do @(negedge clk);
    while (frame_requests.size() != 0 || frame_bus.valid || capture_replies.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, int v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_BITS'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idle(int mode);
    idle_mode = mode;
    send_idle_pct = (mode == IDLE_RX_HEAVY) ? 12 : (mode == IDLE_TX_HEAVY) ? 86 : 0;
    recv_idle_pct = (mode == IDLE_RX_HEAVY) ? 86 : (mode == IDLE_TX_HEAVY) ? 12 : 0;
  endtask

  // Reconfigure while idle, then queue one phase of random traffic.
  // Raising the channel count would expose unwritten entries, so arm first then.
  task automatic run_phase(int ch, int level, bit rise, int chans, int mode, int count,
                           bit carry_only);
    int target;
    int new_nch;
    bit arm_first;
    wait_idle();
    write_reg(CFG_TRIGGER_CHANNEL, ch);
    write_reg(CFG_TRIGGER_LEVEL, level);
    write_reg(CFG_RISING_EDGE, int'(rise));
    write_reg(CFG_CHANNELS_USED, chans);
    new_nch = (chans > CHANNELS) ? CHANNELS : chans;
    arm_first = (new_nch > gen_nch);
    gen_trig_ch = ch;
    gen_level = level;
    gen_rising = rise;
    gen_nch = new_nch;
    @(negedge clk);
    set_idle(mode);
    target = planned + count;
    if (arm_first) push_plain(REQ_ARM);
    while (planned < target) begin
      if (carry_only) begin
        // Keep a running capture going: frames and reads only
        if ($urandom_range(2, 0) == 0)
          push_read($urandom_range(40, 0), $urandom_range(CHANNELS - 1, 0));
        else
          push_frame(SIDE_ANY);
      end else if ($urandom_range(3, 0) != 0) begin
        gen_sequence();
      end else begin
        repeat ($urandom_range(4, 1)) gen_noise();
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    frame_bus.valid = 1'b0;
    frame_bus.req_type = REQ_NONE;
    frame_bus.sample_ch0 = '0;
    frame_bus.sample_ch1 = '0;
    frame_bus.sample_ch2 = '0;
    frame_bus.sample_ch3 = '0;
    frame_bus.read_index = '0;
    frame_bus.read_channel = '0;
    result_bus.ready = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings, rising edge on channel 0 at level 0
    @(negedge clk);
    set_idle(IDLE_RX_HEAVY);
    push_read(0, 0);
    push_samples(32767, 32767, 32767, 32767);
    push_plain(REQ_NONE);
    push_plain(REQ_ARM);
    push_samples(0, 1, 2, 3);
    push_samples(-32768, 32767, 32767, 32767);
    push_samples(0, -1, -2, -3);
    push_samples(32767, -32768, 32767, -32768);
    push_samples(-32768, -32768, -32768, -32768);
    push_samples(32767, 32767, 32767, 32767);
    push_samples(-1, 12345, -12345, 77);
    push_read(0, 0);
    push_read(0, 1);
    push_read(0, 2);
    push_read(0, 3);
    push_read(3, 3);
    push_read(4, 1);
    push_read(CAPTURE_DEPTH - 1, 2);
    push_plain(REQ_NONE);
    push_plain(REQ_ARM);
    push_read(0, 0);
    push_samples(5, 0, 0, 0);

    // Random phases over the register space, extremes included
    run_phase(3, int'($urandom_range(4000, 0)) - 2000, 1'b0, 4, IDLE_RX_HEAVY, 120, 1'b0);
    run_phase(2, -32768, 1'b1, 2, IDLE_RX_HEAVY, 30, 1'b1);
    run_phase(1, 32767, 1'b1, 0, IDLE_TX_HEAVY, 25, 1'b1);
    run_phase(1, -32768, 1'b1, 1, IDLE_TX_HEAVY, 60, 1'b0);
    run_phase(2, 32767, 1'b1, 3, IDLE_TX_HEAVY, 40, 1'b0);
    run_phase(1, int'($urandom_range(600, 0)) - 300, 1'b1, 7, IDLE_NONE, 150, 1'b0);
    fill_memory();
    run_phase(0, 0, 1'b0, 4, IDLE_NONE, 100, 1'b0);

    wait_idle();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS edge_triggered_multichannel_capture_top");
    end else begin
      $display("FAIL edge_triggered_multichannel_capture_top");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/etc_pkg.sv
rtl/etc_if.sv
rtl/edge_triggered_multichannel_capture_top.sv
dv/testbench.sv
